// ===== rtl/twm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twm_pkg
// shared widths, codes and types of the timestamp window matcher
// ----------------------------------------------------------------------------
package twm_pkg;

   localparam int STAMP_W         = 63;
   localparam int WINDOW_W        = 32;
   localparam int COUNT_W         = 11;
   localparam int INDEX_W         = 10;
   localparam int STATUS_W        = 3;
   localparam int CSR_ADDR_W      = 2;
   localparam int CSR_DATA_W      = 32;
   localparam int TABLE_DEPTH_DEF = 1024;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET      = WINDOW_W'(3000000);
   localparam logic [COUNT_W-1:0]  MAX_MATCHES_RESET = COUNT_W'(500);
   localparam logic [COUNT_W-1:0]  COUNT_MAX         = '1;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_ADDR_W-1:0] CSR_WINDOW      = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_MATCHES = CSR_ADDR_W'(1);

   typedef enum logic [STATUS_W-1:0] {
      ST_LOADED = 3'd0,
      ST_FULL   = 3'd1,
      ST_MATCH  = 3'd2,
      ST_MISS   = 3'd3,
      ST_LIMIT  = 3'd4
   } status_type;

   typedef struct packed {
      logic [WINDOW_W-1:0] window;
      logic [COUNT_W-1:0]  max_matches;
   } cfg_type;

   typedef struct packed {
      status_type          status;
      logic [INDEX_W-1:0]  ref_index;
      logic [STAMP_W-1:0]  ref_stamp;
      logic [STAMP_W-1:0]  query_stamp;
      logic [COUNT_W-1:0]  match_count;
   } res_type;

endpackage
`default_nettype wire

// ===== rtl/twm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twm_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module twm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/twm_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// twm_engine
// item control: table loads, window search over the table ram, match state
// ----------------------------------------------------------------------------
module twm_engine #(
   parameter int TABLE_DEPTH = twm_pkg::TABLE_DEPTH_DEF,
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_mode,
   input  wire logic [twm_pkg::STAMP_W-1:0] req_stamp_ns,
   input  wire twm_pkg::cfg_type         cfg,
   output logic                          ram_we,
   output logic      [AW-1:0]            ram_waddr,
   output logic      [twm_pkg::STAMP_W-1:0] ram_wdata,
   output logic                          ram_re,
   output logic      [AW-1:0]            ram_raddr,
   input  wire logic [twm_pkg::STAMP_W-1:0] ram_rdata,
   output logic                          res_valid,
   input  wire logic                     res_take,
   output twm_pkg::res_type              res
);
   import twm_pkg::*;

   localparam int CW  = $clog2(TABLE_DEPTH + 1);
   localparam int IXW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_READ = 4'b0010,
      S_CMP  = 4'b0100,
      S_DONE = 4'b1000
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        ref_count_ff, ref_count_in;
   logic [CW-1:0]        resume_pos_ff, resume_pos_in;
   logic [COUNT_W-1:0]   match_total_ff, match_total_in;
   logic [CW-1:0]        scan_ptr_ff, scan_ptr_in;
   logic [STAMP_W-1:0]   query_ff, query_in;
   res_type              res_ff, res_in;

   logic                 limit_hit;
   logic [CW-1:0]        next_ptr;
   logic [STAMP_W:0]     d_qr, d_rq;
   logic [STAMP_W-1:0]   window_ext;
   logic                 hit;
   logic [COUNT_W-1:0]   match_inc;
   logic [IXW-1:0]       idx_ext;

   assign limit_hit  = (cfg.max_matches != '0) && (match_total_ff >= cfg.max_matches);
   assign next_ptr   = scan_ptr_ff + 1'b1;
   assign d_qr       = {1'b0, query_ff} - {1'b0, ram_rdata};
   assign d_rq       = {1'b0, ram_rdata} - {1'b0, query_ff};
   assign window_ext = STAMP_W'(cfg.window);
   assign hit        = d_qr[STAMP_W] ? (d_rq[STAMP_W-1:0] < window_ext)
                                     : (d_qr[STAMP_W-1:0] < window_ext);
   assign match_inc  = (match_total_ff == COUNT_MAX) ? match_total_ff
                                                     : match_total_ff + 1'b1;
   assign idx_ext    = IXW'(scan_ptr_ff);

   always_comb begin
      state_in       = state_ff;
      ref_count_in   = ref_count_ff;
      resume_pos_in  = resume_pos_ff;
      match_total_in = match_total_ff;
      scan_ptr_in    = scan_ptr_ff;
      query_in       = query_ff;
      res_in         = res_ff;
      ram_we         = 1'b0;
      ram_waddr      = ref_count_ff[AW-1:0];
      ram_wdata      = req_stamp_ns;
      ram_re         = 1'b0;
      ram_raddr      = scan_ptr_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in.ref_index   = '0;
               res_in.ref_stamp   = '0;
               res_in.query_stamp = '0;
               res_in.match_count = match_total_ff;
               state_in           = S_DONE;
               if (req_mode == MODE_LOAD) begin
                  if (ref_count_ff == DEPTH_C) begin
                     res_in.status = ST_FULL;
                  end else begin
                     ram_we        = 1'b1;
                     ref_count_in  = ref_count_ff + 1'b1;
                     res_in.status = ST_LOADED;
                  end
               end else if (limit_hit) begin
                  res_in.status = ST_LIMIT;
               end else if (resume_pos_ff == ref_count_ff) begin
                  res_in.status = ST_MISS;
               end else begin
                  scan_ptr_in = resume_pos_ff;
                  query_in    = req_stamp_ns;
                  state_in    = S_READ;
               end
            end
         end
         S_READ: begin
            ram_re   = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit) begin
               res_in.status      = ST_MATCH;
               res_in.ref_index   = idx_ext[INDEX_W-1:0];
               res_in.ref_stamp   = ram_rdata;
               res_in.query_stamp = query_ff;
               res_in.match_count = match_inc;
               match_total_in     = match_inc;
               resume_pos_in      = next_ptr;
               state_in           = S_DONE;
            end else if (next_ptr == ref_count_ff) begin
               res_in.status = ST_MISS;
               state_in      = S_DONE;
            end else begin
               scan_ptr_in = next_ptr;
               ram_re      = 1'b1;
               ram_raddr   = next_ptr[AW-1:0];
            end
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         ref_count_ff   <= '0;
         resume_pos_ff  <= '0;
         match_total_ff <= '0;
      end else begin
         state_ff       <= state_in;
         ref_count_ff   <= ref_count_in;
         resume_pos_ff  <= resume_pos_in;
         match_total_ff <= match_total_in;
      end
      scan_ptr_ff <= scan_ptr_in;
      query_ff    <= query_in;
      res_ff      <= res_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   // search never passes what has been loaded
   a_resume_in_table: assert property (@(posedge clock) disable iff (reset)
      resume_pos_ff <= ref_count_ff)
      else $error("resume position beyond loaded entries");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMP) |-> (scan_ptr_ff < ref_count_ff))
      else $error("compare of an entry that was never loaded");

   // table is never rewritten while a search reads it
   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_IDLE))
      else $error("table write outside idle");

   a_total_monotonic: assert property (@(posedge clock) disable iff (reset)
      ##1 (match_total_ff >= $past(match_total_ff)))
      else $error("match total went down");

endmodule
`default_nettype wire

// ===== rtl/timestamp_window_matcher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timestamp_window_matcher
// loads reference timestamps into a table and matches query timestamps
// against it within an exclusive window, resuming after each match
// ----------------------------------------------------------------------------
//  port group  dir  handshake           payload
//  req_        in   req_valid/stall     mode, stamp_ns
//  rsp_        out  rsp_valid/stall     status, ref_index, ref_stamp_ns,
//                                       query_stamp_ns, matches_so_far
//  csr_        in   csr_we              csr_index, csr_wdata
//
//  load, limit and empty-search queries go from idle straight to done
//  a query that searches compares entries from the resume position,
//  one entry per cycle through the table ram read port
//  synchronous reset clears counts and control; the table needs no clearing
//  one finished item waits in the output register while the next is taken
// ----------------------------------------------------------------------------
module timestamp_window_matcher #(
   parameter int TABLE_DEPTH = twm_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_mode,
   input  wire logic [twm_pkg::STAMP_W-1:0]   req_stamp_ns,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [twm_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [twm_pkg::INDEX_W-1:0]   rsp_ref_index,
   output logic      [twm_pkg::STAMP_W-1:0]   rsp_ref_stamp_ns,
   output logic      [twm_pkg::STAMP_W-1:0]   rsp_query_stamp_ns,
   output logic      [twm_pkg::COUNT_W-1:0]   rsp_matches_so_far,
   input  wire logic                          csr_we,
   input  wire logic [twm_pkg::CSR_ADDR_W-1:0] csr_index,
   input  wire logic [twm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import twm_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   cfg_type             cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   res_type             rsp_ff, rsp_in;

   logic                ram_we;
   logic [AW-1:0]       ram_waddr;
   logic [STAMP_W-1:0]  ram_wdata;
   logic                ram_re;
   logic [AW-1:0]       ram_raddr;
   logic [STAMP_W-1:0]  ram_rdata;
   logic                res_valid;
   logic                res_take;
   res_type             res;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW: begin
               cfg_in.window = csr_wdata[WINDOW_W-1:0];
            end
            CSR_MAX_MATCHES: begin
               cfg_in.max_matches = csr_wdata[COUNT_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   assign res_take     = res_valid && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = res_take || (rsp_valid_ff && rsp_stall);
   assign rsp_in       = res_take ? res : rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window      <= WINDOW_RESET;
         cfg_ff.max_matches <= MAX_MATCHES_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   twm_ram #(
      .WIDTH (STAMP_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   twm_engine #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_stamp_ns (req_stamp_ns),
      .cfg          (cfg_ff),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_re       (ram_re),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .res_valid    (res_valid),
      .res_take     (res_take),
      .res          (res)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_ff.status;
   assign rsp_ref_index      = rsp_ff.ref_index;
   assign rsp_ref_stamp_ns   = rsp_ff.ref_stamp;
   assign rsp_query_stamp_ns = rsp_ff.query_stamp;
   assign rsp_matches_so_far = rsp_ff.match_count;

endmodule
`default_nettype wire
